@@ src/hst_pkg.sv @@
// ----------------------------------------------------------------------------
// Heading slew tracker package
// Shared widths, constants, the CORDIC arctangent table and the result type.
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam int CORDIC_STEPS   = 16;
	localparam int ATAN_TABLE_LEN = 24;
	localparam int CORDIC_ITERS   = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
	                                                                 : ATAN_TABLE_LEN;
	localparam int ITER_W         = $clog2(ATAN_TABLE_LEN);
	localparam int COORD_W        = 16;
	localparam int VEC_W          = 20;
	localparam int ANG_W          = 16;
	localparam int ACC_W          = 32;

	localparam logic [ANG_W-1:0] TURN_STEP_RESET = 16'd1092;
	localparam logic [ANG_W-1:0] HALF_TURN       = 16'h8000;
	localparam logic [ACC_W-1:0] ACC_HALF_TURN   = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ACC_ROUND       = 32'h0000_8000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ANG_W-1:0] angle_t;

	typedef struct packed {
		logic   done;
		angle_t angle;
	} hst_cordic_res_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [ACC_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
		logic [ACC_W-1:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ src/hst_ifs.sv @@
// ----------------------------------------------------------------------------
// Heading slew tracker channels
// Valid/ready channels for direction vectors, results and the step register.
// ----------------------------------------------------------------------------
interface hst_vec_if import hst_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t dir_x;
	coord_t dir_z;
	modport source (output valid, output dir_x, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_z, output ready);
endinterface

interface hst_hdg_if import hst_pkg::*;;
	logic   valid;
	logic   ready;
	angle_t heading;
	angle_t facing;
	angle_t target_heading;
	modport source (output valid, output heading, output facing, output target_heading,
		input ready);
	modport sink (input valid, input heading, input facing, input target_heading,
		output ready);
endinterface

interface hst_cfg_if import hst_pkg::*;;
	logic   valid;
	logic   ready;
	angle_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/heading_slew_tracker.sv @@
// ----------------------------------------------------------------------------
// Heading slew tracker
// Turns a stored heading toward atan2 of each direction vector, rate limited.
// ----------------------------------------------------------------------------
// Usage notes.
// The vec channel takes one direction vector (dir_x, dir_z) per transfer. The
// block works out the target heading with a CORDIC of 16 rotations, moves the
// stored heading toward it by no more than turn_step, and offers the new
// heading, the facing (heading plus a half turn) and the target on the hdg
// channel as one transfer.
// On a vec transfer the CORDIC is loaded at the transfer edge, then makes one
// rotation per cycle, and the slew update is then registered in the output
// register once that is free. The shared CORDIC rotation
// unit sets the rate: vec.ready returns in the same cycle as hdg valid, so no
// new vector is taken until the last one's result is in the output register.
// If the receiver stalls, the result stays in the output register and a new
// vector is still taken; that vector's result waits in the CORDIC until the
// output register is free.
// The cfg channel writes turn_step and is always ready; write it only while
// the block is idle. Reset sets the heading to zero and turn_step to 1092.
// ----------------------------------------------------------------------------
module heading_slew_tracker import hst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hst_vec_if.sink   vec,
	hst_hdg_if.source hdg,
	hst_cfg_if.sink   cfg
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CORD = 1'b1;

	logic            state_q;
	logic            out_valid_q;
	angle_t          heading_q;
	angle_t          turn_step_q;
	angle_t          out_heading_q;
	angle_t          out_facing_q;
	angle_t          out_target_q;

	hst_cordic_res_t cres;
	logic            vec_xfer;
	logic            out_free;
	logic            load;

	angle_t              raw_diff;
	logic signed [17:0]  diff;
	logic signed [17:0]  step;
	logic signed [17:0]  moved;
	logic signed [17:0]  left;
	angle_t              new_heading;

	assign vec.ready = (state_q == ST_IDLE);
	assign vec_xfer  = vec.valid && vec.ready;
	assign cfg.ready = 1'b1;

	// The output register is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || hdg.ready;
	assign load     = (state_q == ST_CORD) && cres.done && out_free;

	hst_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vec_xfer),
		.dir_x  (vec.dir_x),
		.dir_z  (vec.dir_z),
		.res    (cres)
	);

	// Slew limit: the signed difference to the target shrinks toward zero by at
	// most turn_step, never crossing zero. A difference of exactly a half turn
	// reads as negative and so moves upward.
	always_comb begin
		raw_diff = cres.angle - heading_q;
		diff     = {{2{raw_diff[ANG_W-1]}}, raw_diff};
		step     = {2'b00, turn_step_q};
		if (diff > 0) begin
			moved = diff - step;
			left  = (moved < 0) ? '0 : moved;
		end else begin
			moved = diff + step;
			left  = (moved > 0) ? '0 : moved;
		end
		new_heading = cres.angle - left[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			heading_q   <= '0;
			turn_step_q <= TURN_STEP_RESET;
		end else begin
			if (cfg.valid && cfg.ready) begin
				turn_step_q <= cfg.data;
			end
			case (state_q)
				ST_IDLE: begin
					if (vec_xfer) begin
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (load) begin
						state_q   <= ST_IDLE;
						heading_q <= new_heading;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (hdg.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_heading_q <= new_heading;
			out_facing_q  <= new_heading ^ HALF_TURN;
			out_target_q  <= cres.angle;
		end
	end

	assign hdg.valid          = out_valid_q;
	assign hdg.heading        = out_heading_q;
	assign hdg.facing         = out_facing_q;
	assign hdg.target_heading = out_target_q;

	// A vector transfer always starts a CORDIC run.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		vec_xfer |=> (state_q == ST_CORD))
		else $error("vector transfer did not start the CORDIC");

	// The facing shown is always the heading shown plus a half turn.
	a_facing: assert property (@(posedge clk) disable iff (!arst_n)
		hdg.valid |-> (hdg.facing == (hdg.heading ^ HALF_TURN)))
		else $error("facing differs from heading plus a half turn");

	// A result appears only from a finished CORDIC run.
	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cres.done))
		else $error("result registered before the CORDIC finished");

	// The stored heading and the heading shown move together.
	a_heading_stored: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (hdg.heading == heading_q))
		else $error("stored heading differs from the heading sent");

endmodule

@@ src/hst_cordic.sv @@
// ----------------------------------------------------------------------------
// Heading slew tracker CORDIC
// Vectoring CORDIC, one rotation per cycle, giving atan2(x, z) as a binary angle.
// ----------------------------------------------------------------------------
module hst_cordic import hst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  coord_t          dir_x,
	input  coord_t          dir_z,
	output hst_cordic_res_t res
);

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

	logic                    run_q;
	logic                    done_q;
	logic [ITER_W-1:0]       cnt_q;
	logic signed [VEC_W-1:0] x_q;
	logic signed [VEC_W-1:0] z_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    zero_q;

	logic signed [VEC_W-1:0] x_ext;
	logic signed [VEC_W-1:0] z_ext;
	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] zs;
	logic signed [VEC_W-1:0] x_n;
	logic signed [VEC_W-1:0] z_n;
	logic [ACC_W-1:0]        acc_n;
	logic [ACC_W-1:0]        acc_rnd;

	assign x_ext = {{(VEC_W-COORD_W){dir_x[COORD_W-1]}}, dir_x};
	assign z_ext = {{(VEC_W-COORD_W){dir_z[COORD_W-1]}}, dir_z};

	// One micro-rotation; both updates use the values from before the step.
	always_comb begin
		xs = x_q >>> cnt_q;
		zs = z_q >>> cnt_q;
		if (x_q > 0) begin
			z_n   = z_q + xs;
			x_n   = x_q - zs;
			acc_n = acc_q + atan_entry(cnt_q);
		end else begin
			z_n   = z_q - xs;
			x_n   = x_q + zs;
			acc_n = acc_q - atan_entry(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_ITER) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dir_x == '0) && (dir_z == '0);
			if (dir_z < 0) begin
				x_q   <= -x_ext;
				z_q   <= -z_ext;
				acc_q <= ACC_HALF_TURN;
			end else begin
				x_q   <= x_ext;
				z_q   <= z_ext;
				acc_q <= '0;
			end
		end else if (run_q) begin
			x_q   <= x_n;
			z_q   <= z_n;
			acc_q <= acc_n;
		end
	end

	assign acc_rnd   = acc_q + ACC_ROUND;
	assign res.done  = done_q;
	assign res.angle = zero_q ? '0 : acc_rnd[ACC_W-1:ACC_W-ANG_W];

endmodule

@@ bench/tb_heading_slew_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading slew tracker testbench
// Drives direction vectors and turn step writes into the tracker, predicts
// every heading, facing and target with an independent CORDIC and slew model,
// and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_heading_slew_tracker;
	import hst_pkg::*;

	// The settle wait is the tracker's result latency plus a margin, so that a
	// phase is really over before the register moves.
	localparam int RESULT_LATENCY = 17;
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
	// Slowest correct run is roughly 1300 vectors, plus the
	// long receiver hold-off. The limit leaves plenty of room above that.
	localparam int CYCLE_LIMIT    = 500000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASE_ITEMS = 125;

	// atan(2^-i) in 32-bit binary angle units, 2^32 being one full turn.
	localparam logic [31:0] ATAN_BAM [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		angle_t heading;
		angle_t facing;
		angle_t target;
	} heading_result_t;

	logic clk;
	logic arst_n;

	hst_vec_if vec_ch ();
	hst_hdg_if hdg_ch ();
	hst_cfg_if cfg_ch ();

	heading_slew_tracker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.hdg    (hdg_ch),
		.cfg    (cfg_ch)
	);

	// Predicted results in the order in which their vectors were taken.
	heading_result_t expected_headings [$];

	// Private copy of the tracker state and of the turn step register.
	angle_t tracked_heading;
	angle_t turn_step_now;

	int  mismatch_count;
	int  cycle_count;
	bit  gaps_enabled;
	int  receiver_hold_cycles;

	// Last vector sent, so that the random stimulus can hover around it and
	// let the heading actually catch up with its target now and then.
	coord_t last_x;
	coord_t last_z;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Vectoring CORDIC. A vector in the lower half plane is first turned by a
	// half turn, after which every rotation drives x toward zero. The result is
	// the accumulator rounded to 16 bits.
	function automatic angle_t atan2_bam(input coord_t x, input coord_t z);
		longint      vx;
		longint      vz;
		longint      sx;
		longint      sz;
		logic [31:0] acc;
		if (x == 0 && z == 0)
			return '0;
		vx  = longint'(x);
		vz  = longint'(z);
		acc = '0;
		if (vz < 0) begin
			vx  = -vx;
			vz  = -vz;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			sx = vx >>> i;
			sz = vz >>> i;
			if (vx > 0) begin
				vz  = vz + sx;
				vx  = vx - sz;
				acc = acc + ATAN_BAM[i];
			end else begin
				vz  = vz - sx;
				vx  = vx + sz;
				acc = acc - ATAN_BAM[i];
			end
		end
		acc = acc + 32'h0000_8000;
		return acc[31:16];
	endfunction

	// The difference to the target is taken as a signed half turn, so exactly
	// a half turn counts as negative and is closed from below. It shrinks by
	// the turn step toward zero without crossing it.
	function automatic heading_result_t slew_toward(input angle_t target, input angle_t prev,
			input angle_t slew_limit);
		angle_t          raw;
		int              diff;
		heading_result_t r;
		raw  = target - prev;
		diff = raw[15] ? int'(raw) - 65536 : int'(raw);
		if (diff > 0) begin
			diff = diff - int'(slew_limit);
			if (diff < 0)
				diff = 0;
		end else begin
			diff = diff + int'(slew_limit);
			if (diff > 0)
				diff = 0;
		end
		r.heading = target - angle_t'(diff);
		r.facing  = r.heading + HALF_TURN;
		r.target  = target;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------------

	// Offers one vector and holds it until the transfer. Valid stays high on
	// return, so back-to-back vectors leave no bubble when no gap is drawn.
	task automatic send_direction(input coord_t x, input coord_t z);
		int              gap;
		heading_result_t r;
		gap = gaps_enabled ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			vec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.dir_x <= x;
		vec_ch.dir_z <= z;
		do @(posedge clk); while (!(vec_ch.valid && vec_ch.ready));
		r = slew_toward(atan2_bam(x, z), tracked_heading, turn_step_now);
		tracked_heading = r.heading;
		expected_headings.push_back(r);
		last_x = x;
		last_z = z;
	endtask

	// Stops offering vectors, waits for every pending result to come out and
	// then lets the pipeline settle, so that the block is idle afterwards.
	task automatic close_phase();
		vec_ch.valid <= 1'b0;
		while (expected_headings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called on an idle block, straight after close_phase.
	task automatic write_turn_step(input angle_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		turn_step_now = value;
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------

	// The receiver draws a stall before each result. A pending hold-off request
	// overrides the draw and also breaks off a wait in which ready is high, so
	// the long stretch starts at once.
	initial begin
		int stall;
		hdg_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold_cycles > 0) begin
				stall = receiver_hold_cycles;
				receiver_hold_cycles = 0;
			end else begin
				stall = gaps_enabled ? $urandom_range(0, 8) : 0;
			end
			if (stall > 0) begin
				hdg_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hdg_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!(hdg_ch.valid && hdg_ch.ready) && receiver_hold_cycles == 0);
		end
	end

	// Every result transfer is matched against the oldest prediction. Values
	// are sampled at the edge, before any update scheduled for that edge.
	always @(posedge clk) begin
		heading_result_t want;
		if (arst_n && hdg_ch.valid && hdg_ch.ready) begin
			if (expected_headings.size() == 0) begin
				$error("result transfer with no vector pending: heading %0d target %0d",
					hdg_ch.heading, hdg_ch.target_heading);
				mismatch_count++;
			end else begin
				want = expected_headings.pop_front();
				if (hdg_ch.heading !== want.heading) begin
					$error("heading: expected %0d, actual %0d", want.heading, hdg_ch.heading);
					mismatch_count++;
				end
				if (hdg_ch.facing !== want.facing) begin
					$error("facing: expected %0d, actual %0d", want.facing, hdg_ch.facing);
					mismatch_count++;
				end
				if (hdg_ch.target_heading !== want.target) begin
					$error("target_heading: expected %0d, actual %0d", want.target,
						hdg_ch.target_heading);
					mismatch_count++;
				end
			end
		end
	end

	// A hung handshake ends the run here rather than hanging the simulator.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Straight after reset, with the reset turn step: the zero vector, both
	// axes in both directions, the corners of the input range and the
	// smallest non-zero vectors.
	task automatic test_extremes_at_reset_step();
		send_direction(16'sd0, 16'sd0);
		send_direction(16'sd0, 16'sd16384);
		send_direction(16'sd16384, 16'sd0);
		send_direction(16'sd0, -16'sd16384);
		send_direction(-16'sd16384, 16'sd0);
		send_direction(16'sd32767, 16'sd32767);
		send_direction(-16'sd32768, -16'sd32768);
		send_direction(-16'sd32768, 16'sd32767);
		send_direction(16'sd32767, -16'sd32768);
		send_direction(16'sd1, 16'sd0);
		send_direction(16'sd0, -16'sd1);
		send_direction(-16'sd1, -16'sd1);
		send_direction(16'sd0, 16'sd0);
	endtask

	// With no turn step the heading must not move at all, even when the
	// target lies exactly a half turn away.
	task automatic test_turn_step_zero();
		close_phase();
		write_turn_step(16'd0);
		send_direction(16'sd0, -16'sd16384);
		send_direction(16'sd16384, 16'sd0);
		send_direction(16'sd0, 16'sd0);
	endtask

	// A half-turn step snaps the heading onto every target, including the
	// reversal where the difference is exactly a half turn.
	task automatic test_turn_step_half_turn();
		close_phase();
		write_turn_step(HALF_TURN);
		send_direction(16'sd0, 16'sd16384);
		send_direction(16'sd0, -16'sd16384);
		send_direction(-16'sd16384, 16'sd0);
	endtask

	// Steps beyond a half turn behave as a half turn.
	task automatic test_turn_step_above_half_turn();
		close_phase();
		write_turn_step(16'hFFFF);
		send_direction(16'sd12345, -16'sd23456);
		send_direction(16'sd0, 16'sd0);
	endtask

	// The receiver holds off for a long stretch while vectors keep coming
	// without gaps, so the output register and the CORDIC both fill and the
	// block has to refuse further vectors until the receiver returns.
	task automatic test_output_back_pressure();
		close_phase();
		write_turn_step(16'd2000);
		gaps_enabled = 1'b0;
		receiver_hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < 10; i++)
			send_direction(coord_t'($urandom), coord_t'($urandom));
		gaps_enabled = 1'b1;
	endtask

	// Random vectors under one turn step. Four in ten are full-range values; the rest
	// are tiny vectors, axis vectors, extremes and small moves from the last
	// vector, so that the heading also settles onto its target at times.
	task automatic test_random_directions(input angle_t slew_limit, input bit with_gaps,
			input int count);
		coord_t x;
		coord_t z;
		coord_t corner [5];
		corner = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		close_phase();
		write_turn_step(slew_limit);
		gaps_enabled = with_gaps;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					x = coord_t'($urandom);
					z = coord_t'($urandom);
				end
				4: begin
					x = coord_t'(int'($urandom_range(0, 16)) - 8);
					z = coord_t'(int'($urandom_range(0, 16)) - 8);
				end
				5: begin
					if ($urandom_range(0, 1)) begin
						x = '0;
						z = coord_t'($urandom);
					end else begin
						x = coord_t'($urandom);
						z = '0;
					end
				end
				6: begin
					x = corner[$urandom_range(0, 4)];
					z = corner[$urandom_range(0, 4)];
				end
				default: begin
					x = last_x + coord_t'(int'($urandom_range(0, 512)) - 256);
					z = last_z + coord_t'(int'($urandom_range(0, 512)) - 256);
				end
			endcase
			send_direction(x, z);
		end
		gaps_enabled = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		vec_ch.valid = 1'b0;
		vec_ch.dir_x = '0;
		vec_ch.dir_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;

		mismatch_count       = 0;
		cycle_count          = 0;
		gaps_enabled         = 1'b1;
		receiver_hold_cycles = 0;
		tracked_heading      = '0;
		turn_step_now        = TURN_STEP_RESET;
		last_x               = '0;
		last_z               = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_extremes_at_reset_step();
		test_turn_step_zero();
		test_turn_step_half_turn();
		test_turn_step_above_half_turn();
		test_output_back_pressure();

		// Several settings of the register, the extremes among them; two of
		// the phases run without idling on either side.
		test_random_directions(16'd1, 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(angle_t'($urandom_range(2, 1091)), 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(16'd4096, 1'b0, RANDOM_PHASE_ITEMS);
		test_random_directions(16'd32767, 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(HALF_TURN, 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(16'hFFFF, 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(16'd0, 1'b0, RANDOM_PHASE_ITEMS);
		test_random_directions(angle_t'($urandom_range(0, 65535)), 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(TURN_STEP_RESET, 1'b1, RANDOM_PHASE_ITEMS);
		test_random_directions(16'd512, 1'b1, RANDOM_PHASE_ITEMS);

		close_phase();
		if (mismatch_count == 0 && expected_headings.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ heading_slew_tracker.f @@
src/hst_pkg.sv
src/hst_ifs.sv
src/hst_cordic.sv
src/heading_slew_tracker.sv
bench/tb_heading_slew_tracker.sv
